FILE: sv/cpfp_pkg.sv
// Package for the circle point from phase block: widths, CORDIC arctangent table,
// and shared types. Used by every module of the block; depends on nothing.
package cpfp_pkg;

   localparam int COORD_BITS = 24;
   localparam int PHASE_BITS = 16;
   localparam int CORDIC_STAGES = 20;
   localparam int GUARD_BITS = 4;
   localparam int KINV_BITS = 24;
   localparam int DIR_BITS = 4;
   localparam int CSR_IDX_BITS = 3;
   localparam int VEC_BITS = COORD_BITS + GUARD_BITS + 3;
   localparam int ANG_BITS = 33;
   localparam int SUM_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = VEC_BITS + KINV_BITS + 2;
   localparam logic [KINV_BITS-1:0] KINV_VALUE = 24'd10188014;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_START_X = 3'd0,
      CSR_START_Y = 3'd1,
      CSR_END_X = 3'd2,
      CSR_END_Y = 3'd3,
      CSR_TURN_DIR = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [VEC_BITS-1:0] x;
      logic signed [VEC_BITS-1:0] y;
      logic signed [ANG_BITS-1:0] z;
   } rot_type;

   function automatic logic [31:0] atan_turn(input int i);
      logic [31:0] v;
      v = 32'd0;
      unique case (i)
         0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
         3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
         6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
         9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
         12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
         15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
         18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
         21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
         24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
         27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
         30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

FILE: sv/cpfp_cordic_stage.sv
// One registered rotation-mode CORDIC stage.
// Depends on cpfp_pkg.
module cpfp_cordic_stage (
   input  logic clock,
   input  logic reset,
   input  logic [4:0] stage_idx,
   input  logic in_valid,
   input  cpfp_pkg::rot_type in_rot,
   input  logic signed [cpfp_pkg::SUM_BITS-1:0] in_sx,
   input  logic signed [cpfp_pkg::SUM_BITS-1:0] in_sy,
   output logic out_valid,
   output cpfp_pkg::rot_type out_rot,
   output logic signed [cpfp_pkg::SUM_BITS-1:0] out_sx,
   output logic signed [cpfp_pkg::SUM_BITS-1:0] out_sy
);
   logic valid_ff;
   cpfp_pkg::rot_type rot_ff, rot_in;
   logic signed [cpfp_pkg::SUM_BITS-1:0] sx_ff, sy_ff;
   logic signed [cpfp_pkg::VEC_BITS-1:0] xs, ys;
   logic signed [cpfp_pkg::ANG_BITS-1:0] at;

   always_comb begin
      xs = in_rot.x >>> stage_idx;
      ys = in_rot.y >>> stage_idx;
      at = $signed({1'b0, cpfp_pkg::atan_turn(int'(stage_idx))});
      if (!in_rot.z[cpfp_pkg::ANG_BITS-1]) begin
         rot_in.x = in_rot.x - ys;
         rot_in.y = in_rot.y + xs;
         rot_in.z = in_rot.z - at;
      end else begin
         rot_in.x = in_rot.x + ys;
         rot_in.y = in_rot.y - xs;
         rot_in.z = in_rot.z + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rot_ff <= rot_in;
      sx_ff <= in_sx;
      sy_ff <= in_sy;
   end

   assign out_valid = valid_ff;
   assign out_rot = rot_ff;
   assign out_sx = sx_ff;
   assign out_sy = sy_ff;
endmodule

FILE: sv/cpfp_finish.sv
// Gain correction, center add, rounding and saturation for one coordinate,
// in two register stages. Depends on cpfp_pkg.
module cpfp_finish (
   input  logic clock,
   input  logic signed [cpfp_pkg::VEC_BITS-1:0] rot,
   input  logic signed [cpfp_pkg::SUM_BITS-1:0] sum2,
   output logic signed [cpfp_pkg::COORD_BITS-1:0] result
);
   localparam int SH = cpfp_pkg::KINV_BITS + cpfp_pkg::GUARD_BITS + 1;
   localparam int TB = cpfp_pkg::PROD_BITS + 2;
   logic signed [cpfp_pkg::PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [cpfp_pkg::SUM_BITS-1:0] sum_ff;
   logic signed [TB-1:0] total;
   logic signed [TB-SH-1:0] shifted;
   logic signed [cpfp_pkg::COORD_BITS-1:0] result_ff, result_in;
   localparam logic signed [TB-SH-1:0] HI = (TB-SH)'(2 ** (cpfp_pkg::COORD_BITS - 1) - 1);
   localparam logic signed [TB-SH-1:0] LO = -HI - 1;

   always_comb begin
      prod_in = cpfp_pkg::PROD_BITS'(rot * $signed({1'b0, cpfp_pkg::KINV_VALUE}));
      total = TB'(prod_ff) + (TB'(sum_ff) <<< (SH - 1)) + (TB'(1) <<< (SH - 1));
      shifted = (TB-SH)'(total >>> SH);
      if (shifted > HI) begin
         result_in = cpfp_pkg::COORD_BITS'(HI);
      end else if (shifted < LO) begin
         result_in = cpfp_pkg::COORD_BITS'(LO);
      end else begin
         result_in = cpfp_pkg::COORD_BITS'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff <= sum2;
      result_ff <= result_in;
   end

   assign result = result_ff;
endmodule

FILE: sv/circle_point_from_phase.sv
// Top level of the circle point from phase block: registers, quadrant fold,
// CORDIC pipeline and output stages. Depends on cpfp_pkg and the stage modules.
// One request enters per clock; its result is on rsp_valid after passing the
// angle register, one register per CORDIC stage and the multiply and round
// stages. The receiver cannot stall, and busy is always low. Configure only
// while the pipe is empty.
module circle_point_from_phase (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [cpfp_pkg::PHASE_BITS:0] req_phase,
   output logic rsp_valid,
   output logic signed [cpfp_pkg::COORD_BITS-1:0] rsp_out_x,
   output logic signed [cpfp_pkg::COORD_BITS-1:0] rsp_out_y,
   input  logic csr_we,
   input  logic [cpfp_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [cpfp_pkg::COORD_BITS-1:0] csr_wdata
);
   localparam int N = cpfp_pkg::CORDIC_STAGES;
   localparam int CB = cpfp_pkg::COORD_BITS;
   localparam int VB = cpfp_pkg::VEC_BITS;
   localparam int SB = cpfp_pkg::SUM_BITS;

   logic signed [CB-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [cpfp_pkg::DIR_BITS-1:0] dir_ff;
   logic v0_ff;
   logic [cpfp_pkg::PHASE_BITS-1:0] ang_ff, ang_in;
   logic signed [SB-1:0] dx, dy, sumx, sumy;
   logic [31:0] ang32, rres;
   logic [1:0] q;
   cpfp_pkg::rot_type rot0;
   logic signed [VB-1:0] gx, gy;

   logic valid_w [0:N];
   cpfp_pkg::rot_type rot_w [0:N];
   logic signed [SB-1:0] sx_w [0:N];
   logic signed [SB-1:0] sy_w [0:N];
   logic [2:0] tail_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff <= '0;
         sy_ff <= '0;
         ex_ff <= '0;
         ey_ff <= '0;
         dir_ff <= cpfp_pkg::DIR_BITS'(1);
         v0_ff <= 1'b0;
         tail_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               cpfp_pkg::CSR_START_X: sx_ff <= csr_wdata;
               cpfp_pkg::CSR_START_Y: sy_ff <= csr_wdata;
               cpfp_pkg::CSR_END_X: ex_ff <= csr_wdata;
               cpfp_pkg::CSR_END_Y: ey_ff <= csr_wdata;
               cpfp_pkg::CSR_TURN_DIR: dir_ff <= csr_wdata[cpfp_pkg::DIR_BITS-1:0];
               default: ;
            endcase
         end
         v0_ff <= start && !busy;
         tail_ff <= {tail_ff[1:0], valid_w[N]};
      end
      ang_ff <= ang_in;
   end

   always_comb begin
      ang_in = cpfp_pkg::PHASE_BITS'(
         $signed({1'b0, req_phase}) * dir_ff);
      dx = SB'(sx_ff) - SB'(ex_ff);
      dy = SB'(sy_ff) - SB'(ey_ff);
      sumx = SB'(sx_ff) + SB'(ex_ff);
      sumy = SB'(sy_ff) + SB'(ey_ff);
      gx = VB'(dx) <<< cpfp_pkg::GUARD_BITS;
      gy = VB'(dy) <<< cpfp_pkg::GUARD_BITS;
      ang32 = {ang_ff, {(32 - cpfp_pkg::PHASE_BITS){1'b0}}};
      q = 2'((ang32 + 32'h20000000) >> 30);
      rres = ang32 - {q, 30'd0};
      rot0.z = $signed({rres[31], rres});
      unique case (q)
         2'd1: begin rot0.x = -gy; rot0.y = gx; end
         2'd2: begin rot0.x = -gx; rot0.y = -gy; end
         2'd3: begin rot0.x = gy; rot0.y = -gx; end
         default: begin rot0.x = gx; rot0.y = gy; end
      endcase
   end

   assign valid_w[0] = v0_ff;
   assign rot_w[0] = rot0;
   assign sx_w[0] = sumx;
   assign sy_w[0] = sumy;

   for (genvar i = 0; i < N; i++) begin : g_stage
      cpfp_cordic_stage u_stage (
         .clock(clock), .reset(reset), .stage_idx(5'(i)),
         .in_valid(valid_w[i]), .in_rot(rot_w[i]),
         .in_sx(sx_w[i]), .in_sy(sy_w[i]),
         .out_valid(valid_w[i+1]), .out_rot(rot_w[i+1]),
         .out_sx(sx_w[i+1]), .out_sy(sy_w[i+1])
      );
   end

   cpfp_finish u_fin_x (.clock(clock), .rot(rot_w[N].x), .sum2(sx_w[N]), .result(rsp_out_x));
   cpfp_finish u_fin_y (.clock(clock), .rot(rot_w[N].y), .sum2(sy_w[N]), .result(rsp_out_y));

   assign rsp_valid = tail_ff[1];

`ifndef SYNTHESIS
   a_in_to_pipe: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> v0_ff) else $error("request not entered");
   a_pipe_out: assert property (@(posedge clock) disable iff (reset)
      valid_w[N] |=> ##1 rsp_valid) else $error("result lost");
   a_no_busy: assert property (@(posedge clock) !busy) else $error("busy raised");
`endif
endmodule
